[design/kt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kt_pkg: shared definitions of the Kendall tau correlator
// Field widths, the token control group that travels down the cell chain,
// and the state type of the result engine.
// ----------------------------------------------------------------------------
package kt_pkg;

    localparam int MAX_PAIRS_DEF = 1024;   // default cell count
    localparam int SAMPLE_W      = 32;     // Q16.16 sample width
    localparam int TAU_W         = 16;     // Q2.14 result width
    localparam int TOTAL_W       = 19;     // reported pair count width
    localparam int USED_W        = 11;     // reported item count width
    localparam int QUO_W         = 15;     // quotient bits, tau magnitude <= 16384
    localparam int STEP_W        = 4;      // counts the quotient bits

    // Control group of one token in the chain.
    typedef struct packed {
        logic valid;   // a token occupies this stage
        logic last;    // token closes the data set
        logic keep;    // token is stored (store was not full)
        logic seek;    // token has not reached its own slot yet
    } kt_tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } kt_state_t;

endpackage

[design/kt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kt_cell: one cell of the comparison chain
// Holds one stored sample pair. A passing token that still seeks its slot
// either claims this cell as its slot or is compared against the pair held here.
// ----------------------------------------------------------------------------
module kt_cell
    import kt_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF,
    parameter int CELL_IDX  = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  kt_tok_t                      tok_i,
    input  logic [$clog2(MAX_PAIRS)-1:0] idx_i,
    input  logic signed [SAMPLE_W-1:0]   x_i,
    input  logic signed [SAMPLE_W-1:0]   y_i,
    input  logic [$clog2(MAX_PAIRS)-1:0] c_i,
    input  logic [$clog2(MAX_PAIRS)-1:0] d_i,
    output kt_tok_t                      tok_o,
    output logic [$clog2(MAX_PAIRS)-1:0] idx_o,
    output logic signed [SAMPLE_W-1:0]   x_o,
    output logic signed [SAMPLE_W-1:0]   y_o,
    output logic [$clog2(MAX_PAIRS)-1:0] c_o,
    output logic [$clog2(MAX_PAIRS)-1:0] d_o
);

    localparam int IW = $clog2(MAX_PAIRS);

    logic signed [SAMPLE_W-1:0] sx_reg;
    logic signed [SAMPLE_W-1:0] sy_reg;
    kt_tok_t                    tok_reg;
    kt_tok_t                    tok_next;
    logic [IW-1:0]              idx_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic [IW-1:0]              c_reg;
    logic [IW-1:0]              d_reg;

    logic hit;
    logic cmp;
    logic xgt, xlt, ygt, ylt;
    logic conc, disc;

    always_comb begin
        hit  = tok_i.valid && tok_i.keep && tok_i.seek && (idx_i == IW'(CELL_IDX));
        cmp  = tok_i.valid && tok_i.keep && tok_i.seek && !hit;
        xgt  = sx_reg > x_i;
        xlt  = sx_reg < x_i;
        ygt  = sy_reg > y_i;
        ylt  = sy_reg < y_i;
        conc = cmp && ((xgt && ygt) || (xlt && ylt));
        disc = cmp && ((xgt && ylt) || (xlt && ygt));
        tok_next      = tok_i;
        tok_next.seek = tok_i.seek && !hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else if (adv) begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_reg <= idx_i;
            x_reg   <= x_i;
            y_reg   <= y_i;
            c_reg   <= c_i + IW'(conc);
            d_reg   <= d_i + IW'(disc);
            if (hit) begin
                sx_reg <= x_i;
                sy_reg <= y_i;
            end
        end
    end

    assign tok_o = tok_reg;
    assign idx_o = idx_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign c_o   = c_reg;
    assign d_o   = d_reg;

endmodule

[design/kt_result.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kt_result: accumulation and tau division at the end of the chain
// Sums the per-token counts of a data set and, on the closing token, forms
// tau-a with a restoring divider of one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kt_result
    import kt_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  kt_tok_t                      tok_i,
    input  logic [$clog2(MAX_PAIRS)-1:0] c_i,
    input  logic [$clog2(MAX_PAIRS)-1:0] d_i,
    output logic                         adv_o,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [TAU_W-1:0]      m_tau_q14,
    output logic [TOTAL_W-1:0]           m_concordant_total,
    output logic [TOTAL_W-1:0]           m_discordant_total,
    output logic [USED_W-1:0]            m_pairs_used,
    output logic                         m_capacity_overflow
);

    localparam int     NW       = $clog2(MAX_PAIRS + 1);
    localparam longint MAX_CNT  = longint'(MAX_PAIRS) * (MAX_PAIRS - 1) / 2;
    localparam int     AW       = $clog2(MAX_CNT + 1);
    localparam int     DW       = 2 * NW;

    kt_state_t         state_reg, state_next;
    logic [AW-1:0]     acc_c_reg, acc_c_next;
    logic [AW-1:0]     acc_d_reg, acc_d_next;
    logic [NW-1:0]     n_reg, n_next;
    logic              drop_reg, drop_next;
    logic [AW-1:0]     res_c_reg, res_c_next;
    logic [AW-1:0]     res_d_reg, res_d_next;
    logic [NW-1:0]     res_n_reg, res_n_next;
    logic              res_drop_reg, res_drop_next;
    logic              neg_reg, neg_next;
    logic [DW-1:0]     den_reg, den_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [AW-1:0] sum_c;
    logic [AW-1:0] sum_d;
    logic [NW-1:0] sum_n;
    logic          sum_drop;
    logic          take;
    logic [AW-1:0] mag;
    logic [DW:0]   rem_sh;
    logic          rem_ge;

    // The chain stalls only when a closing token waits for a busy engine.
    assign adv_o = !(tok_i.valid && tok_i.last && (state_reg != ST_IDLE));
    assign take  = adv_o && tok_i.valid;

    always_comb begin
        sum_c    = acc_c_reg + (tok_i.keep ? AW'(c_i) : AW'(0));
        sum_d    = acc_d_reg + (tok_i.keep ? AW'(d_i) : AW'(0));
        sum_n    = n_reg + NW'(tok_i.keep);
        sum_drop = drop_reg || !tok_i.keep;
        mag      = (res_d_reg > res_c_reg) ? (res_d_reg - res_c_reg)
                                           : (res_c_reg - res_d_reg);
        rem_sh   = {rem_reg, 1'b0};
        rem_ge   = rem_sh >= {1'b0, den_reg};

        state_next    = state_reg;
        acc_c_next    = acc_c_reg;
        acc_d_next    = acc_d_reg;
        n_next        = n_reg;
        drop_next     = drop_reg;
        res_c_next    = res_c_reg;
        res_d_next    = res_d_reg;
        res_n_next    = res_n_reg;
        res_drop_next = res_drop_reg;
        neg_next      = neg_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;

        if (take) begin
            if (tok_i.last) begin
                res_c_next    = sum_c;
                res_d_next    = sum_d;
                res_n_next    = sum_n;
                res_drop_next = sum_drop;
                acc_c_next    = '0;
                acc_d_next    = '0;
                n_next        = '0;
                drop_next     = 1'b0;
                state_next    = ST_MUL;
            end else begin
                acc_c_next = sum_c;
                acc_d_next = sum_d;
                n_next     = sum_n;
                drop_next  = sum_drop;
            end
        end

        case (state_reg)
            ST_IDLE: begin
            end
            ST_MUL: begin
                den_next  = DW'(res_n_reg) * DW'(res_n_reg - NW'(1));
                neg_next  = res_d_reg > res_c_reg;
                rem_next  = DW'(mag);
                quo_next  = '0;
                step_next = '0;
                if (res_n_reg < NW'(2)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = rem_ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
                quo_next  = {quo_reg[QUO_W-2:0], rem_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_c_reg <= '0;
            acc_d_reg <= '0;
            n_reg     <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_c_reg <= acc_c_next;
            acc_d_reg <= acc_d_next;
            n_reg     <= n_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_c_reg    <= res_c_next;
        res_d_reg    <= res_d_next;
        res_n_reg    <= res_n_next;
        res_drop_reg <= res_drop_next;
        neg_reg      <= neg_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
    end

    assign m_valid             = (state_reg == ST_OUT);
    assign m_tau_q14           = neg_reg ? -$signed({1'b0, quo_reg})
                                         :  $signed({1'b0, quo_reg});
    assign m_concordant_total  = TOTAL_W'(res_c_reg);
    assign m_discordant_total  = TOTAL_W'(res_d_reg);
    assign m_pairs_used        = USED_W'(res_n_reg);
    assign m_capacity_overflow = res_drop_reg;

endmodule

[design/kendall_tau_correlation.sv]
`timescale 1ns / 1ps
// Each transaction passes through the registered cells of the chain to its end; a closing one then
// has its divisor formed and, if n >= 2, a divide step per quotient bit before its result is valid.
// Throughput: one item per cycle, set by the chain of MAX_PAIRS cells that all advance together.
// The chain stalls only while a closing item waits for the previous result to be divided and taken.
// Reset (aresetn, synchronous, active low) empties the chain and clears the running counts; the stored
// samples are not cleared, since only slots written in the current data set are compared.
// ----------------------------------------------------------------------------
// kendall_tau_correlation: streaming Kendall tau-a rank correlation
// Stores up to MAX_PAIRS sample pairs in a row of cells. Each new pair
// travels down the row, is compared against every pair stored ahead of it and
// claims its own slot. On the pair marked last, tau-a is formed in Q2.14
// together with the concordant and discordant counts and the item count.
// ----------------------------------------------------------------------------
module kendall_tau_correlation
    import kt_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_x_sample,
    input  logic signed [SAMPLE_W-1:0] s_y_sample,
    input  logic                       s_last_pair,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [TAU_W-1:0]    m_tau_q14,
    output logic [TOTAL_W-1:0]         m_concordant_total,
    output logic [TOTAL_W-1:0]         m_discordant_total,
    output logic [USED_W-1:0]          m_pairs_used,
    output logic                       m_capacity_overflow
);

    localparam int IW = $clog2(MAX_PAIRS);
    localparam int NW = $clog2(MAX_PAIRS + 1);

    // Slot counter: the number of pairs stored in the current data set.
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          adv;
    logic          keep;
    logic          accept;
    kt_tok_t       tok_in;

    // Chain taps. Position 0 is the input, position MAX_PAIRS the chain end.
    kt_tok_t                    tok_w [0:MAX_PAIRS];
    logic [IW-1:0]              idx_w [0:MAX_PAIRS];
    logic signed [SAMPLE_W-1:0] x_w   [0:MAX_PAIRS];
    logic signed [SAMPLE_W-1:0] y_w   [0:MAX_PAIRS];
    logic [IW-1:0]              c_w   [0:MAX_PAIRS];
    logic [IW-1:0]              d_w   [0:MAX_PAIRS];

    assign s_ready = adv;
    assign accept  = s_valid && s_ready;
    assign keep    = cnt_reg < NW'(MAX_PAIRS);

    // A transaction that finds the store full is passed down the chain with
    // keep low, so it compares nothing and only marks the overflow at the end.
    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            if (s_last_pair) begin
                cnt_next = '0;
            end else if (keep) begin
                cnt_next = cnt_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        tok_in.valid = s_valid;
        tok_in.last  = s_last_pair;
        tok_in.keep  = keep;
        tok_in.seek  = keep;
    end

    assign tok_w[0] = tok_in;
    assign idx_w[0] = IW'(cnt_reg);
    assign x_w[0]   = s_x_sample;
    assign y_w[0]   = s_y_sample;
    assign c_w[0]   = '0;
    assign d_w[0]   = '0;

    // Cell k holds the k-th pair of the data set. Since tokens enter in order
    // and move one cell per cycle whenever the chain advances, a token always finds the slots below its
    // own already written by the earlier transactions of its set.
    for (genvar k = 0; k < MAX_PAIRS; k++) begin : g_cell
        kt_cell #(
            .MAX_PAIRS (MAX_PAIRS),
            .CELL_IDX  (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .tok_i   (tok_w[k]),
            .idx_i   (idx_w[k]),
            .x_i     (x_w[k]),
            .y_i     (y_w[k]),
            .c_i     (c_w[k]),
            .d_i     (d_w[k]),
            .tok_o   (tok_w[k+1]),
            .idx_o   (idx_w[k+1]),
            .x_o     (x_w[k+1]),
            .y_o     (y_w[k+1]),
            .c_o     (c_w[k+1]),
            .d_o     (d_w[k+1])
        );
    end

    // The chain end feeds the accumulators and the tau divider.
    kt_result #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_result (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .tok_i               (tok_w[MAX_PAIRS]),
        .c_i                 (c_w[MAX_PAIRS]),
        .d_i                 (d_w[MAX_PAIRS]),
        .adv_o               (adv),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_tau_q14           (m_tau_q14),
        .m_concordant_total  (m_concordant_total),
        .m_discordant_total  (m_discordant_total),
        .m_pairs_used        (m_pairs_used),
        .m_capacity_overflow (m_capacity_overflow)
    );

    // The chain only stalls for a closing token waiting at its end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (tok_w[MAX_PAIRS].valid && tok_w[MAX_PAIRS].last))
        else $error("chain stalled without a closing token at its end");

    // The slot counter never runs past the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NW'(MAX_PAIRS))
        else $error("slot counter exceeded the store depth");

    // A closing transaction starts the next data set at slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_pair) |=> (cnt_reg == '0))
        else $error("slot counter not cleared after a closing transaction");

    // While a result is offered, a closing token at the chain end is not taken
    // yet: a waiting closing token means stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && tok_w[MAX_PAIRS].valid && tok_w[MAX_PAIRS].last) |-> !s_ready)
        else $error("closing token consumed while a result was pending");

endmodule
